// ----- hdl/pzc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pzc_pkg
// Types, constants and table functions shared by the POSTNET ZIP codec.
// ----------------------------------------------------------------------------
package pzc_pkg;

  localparam int unsigned ZipW  = 17;
  localparam int unsigned BarsW = 27;
  localparam int unsigned DigW  = 4;
  localparam int unsigned CodeW = 5;
  localparam int unsigned NumDigits = 5;

  localparam logic [ZipW-1:0] ZipMax = 17'd99999;

  // reciprocal of 1000, exact for any 17-bit value with a shift of 27
  localparam logic [17:0] Recip1000 = 18'd134218;
  localparam int unsigned Recip1000Shift = 27;

  typedef enum logic {
    KIND_ENCODE = 1'b0,
    KIND_DECODE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_RANGE = 2'd1,
    ERR_GROUP = 2'd2
  } error_e;

  typedef logic [DigW-1:0]  dig_t;
  typedef logic [CodeW-1:0] code_t;

  typedef struct packed {
    logic ok;
    dig_t dig;
  } lookup_t;

  typedef struct packed {
    kind_e              kind;
    logic [ZipW-1:0]    zip;
    logic [BarsW-1:0]   bars;
  } in_t;

  typedef struct packed {
    kind_e                       kind;
    logic                        range_err;
    logic                        group_err;
    logic [ZipW-1:0]             zip;
    logic [BarsW-1:0]            bars;
    logic [7:0]                  hi;
    logic [NumDigits-1:0][DigW-1:0] dec_dig;
  } s1_t;

  typedef struct packed {
    kind_e            kind;
    error_e           err;
    logic [ZipW-1:0]  zip;
    logic [BarsW-1:0] bars;
    logic [9:0]       lo;
    dig_t             d4;
    dig_t             d3;
    logic [ZipW-1:0]  p_hi;
    logic [9:0]       p_lo;
  } s2_t;

  typedef struct packed {
    kind_e            kind;
    error_e           err;
    logic [ZipW-1:0]  zip;
    logic [BarsW-1:0] bars;
    dig_t             d4;
    dig_t             d3;
    dig_t             d2;
    logic [6:0]       r2;
  } s3_t;

  typedef struct packed {
    logic [ZipW-1:0]  zip;
    logic [BarsW-1:0] bars;
    error_e           err;
  } res_t;

  // two-of-five code of one decimal digit
  function automatic code_t digit_code(input dig_t d);
    code_t c;
    case (d)
      4'd0:    c = 5'b11000;
      4'd1:    c = 5'b00011;
      4'd2:    c = 5'b00101;
      4'd3:    c = 5'b00110;
      4'd4:    c = 5'b01001;
      4'd5:    c = 5'b01010;
      4'd6:    c = 5'b01100;
      4'd7:    c = 5'b10001;
      4'd8:    c = 5'b10010;
      4'd9:    c = 5'b10100;
      default: c = 5'b00000;
    endcase
    return c;
  endfunction

  // digit of one bar group, ok low when the group is not a valid code
  function automatic lookup_t code_digit(input code_t g);
    lookup_t r;
    r.ok = 1'b1;
    case (g)
      5'b11000: r.dig = 4'd0;
      5'b00011: r.dig = 4'd1;
      5'b00101: r.dig = 4'd2;
      5'b00110: r.dig = 4'd3;
      5'b01001: r.dig = 4'd4;
      5'b01010: r.dig = 4'd5;
      5'b01100: r.dig = 4'd6;
      5'b10001: r.dig = 4'd7;
      5'b10010: r.dig = 4'd8;
      5'b10100: r.dig = 4'd9;
      default: begin
        r.ok  = 1'b0;
        r.dig = 4'd0;
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/pzc_in_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pzc_in_if
// Request channel of the codec: conversion kind, ZIP value and bar pattern.
// ----------------------------------------------------------------------------
interface pzc_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [16:0] zip_value_in;
  logic [26:0] bars_in;

  modport source (output valid, output kind, output zip_value_in, output bars_in,
                  input ready);
  modport sink (input valid, input kind, input zip_value_in, input bars_in,
                output ready);
endinterface
`default_nettype wire

// ----- hdl/pzc_out_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pzc_out_if
// Result channel of the codec: ZIP value, bar pattern and error code.
// ----------------------------------------------------------------------------
interface pzc_out_if;
  logic        valid;
  logic        ready;
  logic [16:0] zip_value_out;
  logic [26:0] bars_out;
  logic [1:0]  error_code;

  modport source (output valid, output zip_value_out, output bars_out,
                  output error_code, input ready);
  modport sink (input valid, input zip_value_out, input bars_out,
                input error_code, output ready);
endinterface
`default_nettype wire

// ----- hdl/postnet_zip_codec.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// postnet_zip_codec
// Five-digit POSTNET encoder and decoder, no check digit.
// ----------------------------------------------------------------------------
// Each transaction converts a ZIP value to a framed 27-bar pattern (kind 0)
// or a 27-bar pattern back to a value (kind 1), bar 0 at bit 26. The block
// is a four-stage pipeline: it takes one transaction every clock cycle
// while the result channel does not stall, the depth being set by
// the constant-reciprocal digit split (one short constant multiply and its
// correction per stage). Back-pressure on the result channel holds every
// stage that has nowhere to go, nothing is dropped. Values above 99999
// report error 1, unknown bar groups error 2, both with zero value and bars.
// Frame bars are not checked on decode.
// ----------------------------------------------------------------------------
module postnet_zip_codec import pzc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pzc_in_if.sink    in_i,
  pzc_out_if.source out_o
);

  in_t  in_data;
  logic s2_valid, s2_ready;
  s2_t  s2_data;
  res_t res;

  assign in_data.kind = kind_e'(in_i.kind);
  assign in_data.zip  = in_i.zip_value_in;
  assign in_data.bars = in_i.bars_in;

  pzc_split u_split (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_i       (in_data),
    .s2_valid_o (s2_valid),
    .s2_ready_i (s2_ready),
    .s2_o       (s2_data)
  );

  pzc_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_valid_i  (s2_valid),
    .s2_ready_o  (s2_ready),
    .s2_i        (s2_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_o       (res)
  );

  assign out_o.zip_value_out = res.zip;
  assign out_o.bars_out      = res.bars;
  assign out_o.error_code    = res.err;

endmodule
`default_nettype wire

// ----- hdl/pzc_split.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pzc_split
// First two pipeline stages: group lookup, range check, split of the value
// into thousands and remainder, top two digits and decode partial sums.
// ----------------------------------------------------------------------------
module pzc_split import pzc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_i,
  output logic      s2_valid_o,
  input  wire logic s2_ready_i,
  output s2_t       s2_o
);

  logic s1_valid_q, s2_valid_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  logic en1, en2;

  assign en2 = !s2_valid_q || s2_ready_i;
  assign en1 = !s1_valid_q || en2;
  assign in_ready_o = en1;

  // stage 1
  always_comb begin
    logic [34:0] prod;
    lookup_t     lk;
    s1_d           = '0;
    s1_d.kind      = in_i.kind;
    s1_d.zip       = in_i.zip;
    s1_d.bars      = in_i.bars;
    s1_d.range_err = (in_i.kind == KIND_ENCODE) && (in_i.zip > ZipMax);
    prod           = 35'(in_i.zip) * 35'(Recip1000);
    s1_d.hi        = prod[Recip1000Shift +: 8];
    s1_d.group_err = 1'b0;
    for (int k = 0; k < NumDigits; k++) begin
      lk = code_digit(in_i.bars[BarsW-2-CodeW*k -: CodeW]);
      s1_d.dec_dig[NumDigits-1-k] = lk.dig;
      if (!lk.ok && in_i.kind == KIND_DECODE) begin
        s1_d.group_err = 1'b1;
      end
    end
  end

  // stage 2
  always_comb begin
    logic [15:0] t;
    s2_d      = '0;
    s2_d.kind = s1_q.kind;
    s2_d.zip  = s1_q.zip;
    s2_d.bars = s1_q.bars;
    if (s1_q.range_err) begin
      s2_d.err = ERR_RANGE;
    end else if (s1_q.group_err) begin
      s2_d.err = ERR_GROUP;
    end else begin
      s2_d.err = ERR_NONE;
    end
    s2_d.lo   = 10'(s1_q.zip - 17'(s1_q.hi) * 17'd1000);
    t         = 16'(s1_q.hi) * 16'd205;
    s2_d.d4   = t[14:11];
    s2_d.d3   = 4'(s1_q.hi - 8'(s2_d.d4) * 8'd10);
    s2_d.p_hi = 17'(s1_q.dec_dig[4]) * 17'd10000 + 17'(s1_q.dec_dig[3]) * 17'd1000;
    s2_d.p_lo = 10'(s1_q.dec_dig[2]) * 10'd100 + 10'(s1_q.dec_dig[1]) * 10'd10
              + 10'(s1_q.dec_dig[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= in_valid_i;
      end
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (en2 && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign s2_valid_o = s2_valid_q;
  assign s2_o       = s2_q;

endmodule
`default_nettype wire

// ----- hdl/pzc_finish.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pzc_finish
// Last two pipeline stages: lower digits, decoded value sum and assembly of
// the framed bar pattern into the output register.
// ----------------------------------------------------------------------------
module pzc_finish import pzc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s2_valid_i,
  output logic      s2_ready_o,
  input  wire s2_t  s2_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_o
);

  logic s3_valid_q, s4_valid_q;
  s3_t  s3_d, s3_q;
  res_t s4_d, s4_q;
  logic en3, en4;

  assign en4 = !s4_valid_q || out_ready_i;
  assign en3 = !s3_valid_q || en4;
  assign s2_ready_o = en3;

  // stage 3
  always_comb begin
    logic [15:0] t;
    s3_d      = '0;
    s3_d.kind = s2_i.kind;
    s3_d.err  = s2_i.err;
    s3_d.bars = s2_i.bars;
    s3_d.d4   = s2_i.d4;
    s3_d.d3   = s2_i.d3;
    t         = 16'(s2_i.lo) * 16'd41;
    s3_d.d2   = t[15:12];
    s3_d.r2   = 7'(s2_i.lo - 10'(s3_d.d2) * 10'd100);
    if (s2_i.kind == KIND_DECODE) begin
      s3_d.zip = s2_i.p_hi + 17'(s2_i.p_lo);
    end else begin
      s3_d.zip = s2_i.zip;
    end
  end

  // stage 4
  always_comb begin
    logic [13:0] t;
    dig_t        d1, d0;
    t  = 14'(s3_q.r2) * 14'd103;
    d1 = t[13:10];
    d0 = 4'(s3_q.r2 - 7'(d1) * 7'd10);
    s4_d.err = s3_q.err;
    if (s3_q.err != ERR_NONE) begin
      s4_d.zip  = '0;
      s4_d.bars = '0;
    end else if (s3_q.kind == KIND_DECODE) begin
      // valid groups re-encode to themselves, only the frame bars are forced
      s4_d.zip  = s3_q.zip;
      s4_d.bars = {1'b1, s3_q.bars[BarsW-2:1], 1'b1};
    end else begin
      s4_d.zip  = s3_q.zip;
      s4_d.bars = {1'b1, digit_code(s3_q.d4), digit_code(s3_q.d3),
                   digit_code(s3_q.d2), digit_code(d1), digit_code(d0), 1'b1};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (en3) begin
        s3_valid_q <= s2_valid_i;
      end
      if (en4) begin
        s4_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && s2_valid_i) begin
      s3_q <= s3_d;
    end
    if (en4 && s3_valid_q) begin
      s4_q <= s4_d;
    end
  end

  assign out_valid_o = s4_valid_q;
  assign out_o       = s4_q;

endmodule
`default_nettype wire
